// ----- design/fxalu_pkg.sv -----
package fxalu_pkg;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_GT = 4'd4, OP_LT = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
    OP_EQ = 4'd8, OP_NE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
    OP_INC = 4'd12, OP_DEC = 4'd13, OP_FROM_INT = 4'd14, OP_TO_INT = 4'd15
  } op_t;

  localparam int unsigned WORD_W = 32;

  typedef struct packed {
    logic [3:0]         kind;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               compare_true;
    logic               divide_by_zero;
  } rsp_t;

endpackage

// ----- design/fxalu_mul.sv -----
// Pipelined unsigned magnitude multiply, split into 32x16 partial products.
module fxalu_mul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);
  logic [47:0] lo;
  logic [47:0] hi;

  always_ff @(posedge clk) begin
    if (en) begin
      lo <= a * {16'd0, b[15:0]};
      hi <= a * {16'd0, b[31:16]};
      p  <= {16'd0, lo} + {hi, 16'd0};
    end
  end
endmodule

// ----- design/fxalu_div.sv -----
// Unrolled restoring divider: Stages registered steps, each resolving an equal
// share of the quotient bits of a (Bits)-bit dividend by a 32-bit divisor.
// The dividend is zero-extended to a whole number of steps per stage.
module fxalu_div #(
  parameter int Bits   = 40,
  parameter int Stages = 5
) (
  input  logic            clk,
  input  logic            en,
  input  logic [Bits-1:0] num,
  input  logic [31:0]     den,
  output logic [Bits-1:0] quo
);
  localparam int Step   = (Bits + Stages - 1) / Stages;
  localparam int Padded = Step * Stages;

  logic [Padded-1:0] q_r   [Stages+1];
  logic [32:0]       rem_r [Stages+1];
  logic [31:0]       den_r [Stages+1];

  always_comb begin
    q_r[0]   = Padded'(num);
    rem_r[0] = '0;
    den_r[0] = den;
  end

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic [Padded-1:0] q_c;
    logic [32:0]       r_c;
    always_comb begin
      q_c = q_r[s];
      r_c = rem_r[s];
      for (int i = 0; i < Step; i++) begin
        r_c = {r_c[31:0], q_c[Padded-1]};
        q_c = {q_c[Padded-2:0], 1'b0};
        if (r_c >= {1'b0, den_r[s]}) begin
          r_c = r_c - {1'b0, den_r[s]};
          q_c[0] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[s+1]   <= q_c;
        rem_r[s+1] <= r_c;
        den_r[s+1] <= den_r[s];
      end
    end
  end

  assign quo = q_r[Stages][Bits-1:0];
endmodule

// ----- design/fixed_point_q24_8_alu_top.sv -----
// Signed 32-bit fixed-point ALU, FRAC_BITS fraction bits (Q24.8 by default).
// Fully pipelined: one request is taken every cycle unless the output is stalled,
// and its result passes through the five-stage divider plus sign and output
// stages. A stall on a valid output freezes the whole pipeline.
// Multiply rounds to nearest with ties away from zero, divide truncates
// toward zero and returns 0 with divide_by_zero set when operand_b is zero.
module fixed_point_q24_8_alu_top #(
  parameter int FRAC_BITS = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  fxalu_pkg::req_t in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output fxalu_pkg::rsp_t out_data
);
  localparam int DivBits = 32 + FRAC_BITS;
  localparam int DivStg  = 5;
  localparam int Depth   = DivStg + 2;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 0: magnitudes and early results
  logic [31:0] mag_a, mag_b;
  logic        neg_a, neg_b;
  logic signed [31:0] a, b;
  logic [31:0] early_val;
  logic        early_cmp;
  assign a     = in_data.operand_a;
  assign b     = in_data.operand_b;
  assign neg_a = a[31];
  assign neg_b = b[31];
  assign mag_a = neg_a ? 32'(-a) : a;
  assign mag_b = neg_b ? 32'(-b) : b;

  always_comb begin
    early_val = '0;
    early_cmp = 1'b0;
    case (fxalu_pkg::op_t'(in_data.kind))
      fxalu_pkg::OP_ADD:      early_val = a + b;
      fxalu_pkg::OP_SUB:      early_val = a - b;
      fxalu_pkg::OP_GT:       early_cmp = a > b;
      fxalu_pkg::OP_LT:       early_cmp = a < b;
      fxalu_pkg::OP_GE:       early_cmp = a >= b;
      fxalu_pkg::OP_LE:       early_cmp = a <= b;
      fxalu_pkg::OP_EQ:       early_cmp = a == b;
      fxalu_pkg::OP_NE:       early_cmp = a != b;
      fxalu_pkg::OP_MIN:      early_val = (a < b) ? a : b;
      fxalu_pkg::OP_MAX:      early_val = (a > b) ? a : b;
      fxalu_pkg::OP_INC:      early_val = a + 32'sd1;
      fxalu_pkg::OP_DEC:      early_val = a - 32'sd1;
      fxalu_pkg::OP_FROM_INT: early_val = a <<< FRAC_BITS;
      fxalu_pkg::OP_TO_INT:   early_val = a >>> FRAC_BITS;
      default:                early_val = '0;
    endcase
  end

  // side pipe: kind, sign, divide-by-zero flag, early result, valid
  logic [3:0]  kind_p  [Depth];
  logic        sgn_p   [Depth];
  logic        dz_p    [Depth];
  logic [31:0] val_p   [Depth];
  logic        cmp_p   [Depth];
  logic        vld_p   [Depth];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Depth; i++) vld_p[i] <= 1'b0;
    end else if (en) begin
      vld_p[0] <= in_valid;
      for (int i = 1; i < Depth; i++) vld_p[i] <= vld_p[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind_p[0] <= in_data.kind;
      sgn_p[0]  <= neg_a ^ neg_b;
      dz_p[0]   <= (b == '0);
      val_p[0]  <= early_val;
      cmp_p[0]  <= early_cmp;
      for (int i = 1; i < Depth; i++) begin
        kind_p[i] <= kind_p[i-1];
        sgn_p[i]  <= sgn_p[i-1];
        dz_p[i]   <= dz_p[i-1];
        val_p[i]  <= val_p[i-1];
        cmp_p[i]  <= cmp_p[i-1];
      end
    end
  end

  // multiply: pipelined, padded to divider depth
  logic [63:0] prod;
  fxalu_mul u_mul (.clk(clk), .en(en), .a(mag_a), .b(mag_b), .p(prod));

  logic [31:0] mul_q [DivStg-2];
  logic [63:0] rnd;
  assign rnd = (prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  always_ff @(posedge clk) begin
    if (en) begin
      mul_q[0] <= rnd[31:0];
      for (int i = 1; i < DivStg - 2; i++) mul_q[i] <= mul_q[i-1];
    end
  end

  // divide: 5 stages
  logic [DivBits-1:0] quo;
  fxalu_div #(.Bits(DivBits), .Stages(DivStg)) u_div (
    .clk(clk), .en(en),
    .num({mag_a, FRAC_BITS'(0)}), .den(mag_b), .quo(quo)
  );

  // stage DivStg: apply sign
  logic [31:0] mag_r;
  logic [31:0] sel_mag;
  always_comb begin
    case (fxalu_pkg::op_t'(kind_p[DivStg-1]))
      fxalu_pkg::OP_MUL: sel_mag = mul_q[DivStg-3];
      fxalu_pkg::OP_DIV: sel_mag = dz_p[DivStg-1] ? 32'd0 : quo[31:0];
      default:           sel_mag = val_p[DivStg-1];
    endcase
  end
  always_ff @(posedge clk) begin
    if (en) mag_r <= sel_mag;
  end

  logic [31:0] fin;
  always_comb begin
    case (fxalu_pkg::op_t'(kind_p[DivStg]))
      fxalu_pkg::OP_MUL, fxalu_pkg::OP_DIV: fin = sgn_p[DivStg] ? 32'(-mag_r) : mag_r;
      default:                              fin = mag_r;
    endcase
  end

  logic [31:0] out_val_r;
  logic        out_cmp_r, out_dz_r;
  always_ff @(posedge clk) begin
    if (en) begin
      out_val_r <= fin;
      out_cmp_r <= cmp_p[DivStg];
      out_dz_r  <= dz_p[DivStg] && (kind_p[DivStg] == fxalu_pkg::OP_DIV);
    end
  end

  assign out_valid               = vld_p[Depth-1];
  assign out_data.value          = out_val_r;
  assign out_data.compare_true   = out_cmp_r;
  assign out_data.divide_by_zero = out_dz_r;
endmodule

// ----- design/fxalu_check.sv -----
module fxalu_check (
  input logic            clk,
  input logic            rst,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input fxalu_pkg::rsp_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled response changed");
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall not tied to output backpressure");
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.compare_true && out_data.divide_by_zero))
    else $error("compare and divide flags both set");
  a_dz_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.divide_by_zero |-> out_data.value == '0)
    else $error("divide by zero with nonzero value");
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("valid out after reset");
endmodule

bind fixed_point_q24_8_alu_top fxalu_check u_check (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

// ----- tb/sv/tb_top.sv -----
module tb_top;
  import fxalu_pkg::*;

  localparam int FRAC = 8;
  localparam int LATENCY = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int N_RANDOM = 450;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  req_t in_data;
  logic out_valid;
  logic out_stall;
  rsp_t out_data;

  fixed_point_q24_8_alu_top #(.FRAC_BITS(FRAC)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  typedef struct {
    op_t         op;
    logic [31:0] a;
    logic [31:0] b;
    bit          known;
    rsp_t        res;
  } row_t;

  rsp_t alu_expected[$];
  req_t requests[$];
  int   mismatches;
  int   table_errors;
  int   cycles;
  int   results_seen;
  int   ops_seen[16];
  bit   calm;

  function automatic rsp_t alu_model(req_t r);
    rsp_t        o;
    logic signed [31:0] a, b;
    logic [63:0] ma, mb, p, n;
    bit          neg;
    a = r.operand_a;
    b = r.operand_b;
    o = '0;
    ma = a[31] ? 64'(-64'(signed'(a))) : 64'(a);
    mb = b[31] ? 64'(-64'(signed'(b))) : 64'(b);
    neg = a[31] != b[31];
    case (op_t'(r.kind))
      OP_ADD: o.value = a + b;
      OP_SUB: o.value = a - b;
      OP_MUL: begin
        p = ((ma * mb) + (64'd1 << (FRAC - 1))) >> FRAC;
        o.value = neg ? -p[31:0] : p[31:0];
      end
      OP_DIV: begin
        if (b == 0) begin
          o.divide_by_zero = 1'b1;
        end else begin
          n = (ma << FRAC) / mb;
          o.value = neg ? -n[31:0] : n[31:0];
        end
      end
      OP_GT: o.compare_true = a > b;
      OP_LT: o.compare_true = a < b;
      OP_GE: o.compare_true = a >= b;
      OP_LE: o.compare_true = a <= b;
      OP_EQ: o.compare_true = a == b;
      OP_NE: o.compare_true = a != b;
      OP_MIN: o.value = (a < b) ? a : b;
      OP_MAX: o.value = (a > b) ? a : b;
      OP_INC: o.value = a + 32'sd1;
      OP_DEC: o.value = a - 32'sd1;
      OP_FROM_INT: o.value = a <<< FRAC;
      default: o.value = a >>> FRAC;
    endcase
    return o;
  endfunction

  function automatic row_t mk(op_t op, logic [31:0] a, logic [31:0] b, bit known = 0,
                              logic [31:0] v = 0, logic c = 0, logic z = 0);
    row_t r;
    r.op = op; r.a = a; r.b = b; r.known = known;
    r.res.value = v; r.res.compare_true = c; r.res.divide_by_zero = z;
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7fff_fffc + $urandom_range(0, 3);
      2: return $urandom_range(0, 2) - 1;
      3: return $urandom_range(0, 4096) - 2048;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // sender: drains requests; holds payload while stalled
  int idle_left;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
      idle_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        alu_expected.push_back(alu_model(in_data));
        ops_seen[in_data.kind]++;
      end
      if (!in_valid || !in_stall) begin
        if (idle_left > 0 && !calm) begin
          idle_left--;
          in_valid <= 1'b0;
        end else if (requests.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= requests.pop_front();
          if (!calm && $urandom_range(0, 7) == 0) idle_left = $urandom_range(1, 10);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  int stall_left;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (stall_left > 0) stall_left--;
      else if (!calm && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 10);
      out_stall <= (stall_left > 0);
    end
  end

  // checker: compare each result against the oldest prediction
  always @(posedge clk) begin
    rsp_t e;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (alu_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        e = alu_expected.pop_front();
        if (out_data !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected v=%h c=%b z=%b got v=%h c=%b z=%b",
                     e.value, e.compare_true, e.divide_by_zero,
                     out_data.value, out_data.compare_true, out_data.divide_by_zero);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  row_t table_rows[$];
  req_t q;
  rsp_t known_res[$];

  initial begin
    calm = 0;
    rst = 1'b1;
    table_rows = '{
      mk(OP_ADD, 32'h7fff_ffff, 32'h1, 1, 32'h8000_0000),
      mk(OP_SUB, 32'h8000_0000, 32'h1, 1, 32'h7fff_ffff),
      mk(OP_MUL, 32'h100, 32'hffff_ff00, 1, 32'hffff_ff00),
      mk(OP_MUL, 32'h1, 32'h80),
      mk(OP_MUL, 32'hffff_ffff, 32'h80),
      mk(OP_MUL, 32'h8000_0000, 32'h8000_0000),
      mk(OP_DIV, 32'h1234, 32'h0, 1, 32'h0, 0, 1),
      mk(OP_DIV, 32'h8000_0000, 32'h1),
      mk(OP_DIV, 32'hffff_fd00, 32'h200),
      mk(OP_GT, 32'h1, 32'h8000_0000, 1, 0, 1),
      mk(OP_LT, 32'h8000_0000, 32'h7fff_ffff, 1, 0, 1),
      mk(OP_GE, 32'h5, 32'h5, 1, 0, 1),
      mk(OP_LE, 32'h6, 32'h5, 1, 0, 0),
      mk(OP_EQ, 32'hffff_ffff, 32'hffff_ffff, 1, 0, 1),
      mk(OP_NE, 32'h0, 32'h0, 1, 0, 0),
      mk(OP_MIN, 32'h8000_0000, 32'h7fff_ffff, 1, 32'h8000_0000),
      mk(OP_MAX, 32'h8000_0000, 32'h7fff_ffff, 1, 32'h7fff_ffff),
      mk(OP_INC, 32'h7fff_ffff, 32'hffff_ffff, 1, 32'h8000_0000),
      mk(OP_DEC, 32'h8000_0000, 32'hffff_ffff, 1, 32'h7fff_ffff),
      mk(OP_FROM_INT, 32'h00ff_ffff, 32'h0, 1, 32'hffff_ff00),
      mk(OP_TO_INT, 32'hffff_ff01, 32'h0, 1, 32'hffff_ffff),
      mk(OP_TO_INT, 32'h7fff_ffff, 32'h0, 1, 32'h007f_ffff)
    };
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    foreach (table_rows[i]) begin
      q.kind = table_rows[i].op;
      q.operand_a = table_rows[i].a;
      q.operand_b = table_rows[i].b;
      // typed-in rows with a known result must agree with the predictor itself
      if (table_rows[i].known && alu_model(q) !== table_rows[i].res) begin
        table_errors++;
        if (table_errors <= 10) $display("table row %0d disagrees with predictor", i);
      end
      requests.push_back(q);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      q.kind = 4'($urandom_range(0, 15));
      q.operand_a = rand_word();
      q.operand_b = ($urandom_range(0, 9) == 0) ? 32'h0 : rand_word();
      if (q.kind == OP_EQ && $urandom_range(0, 1)) q.operand_b = q.operand_a;
      requests.push_back(q);
      if (i == N_RANDOM - 80) begin
        wait (requests.size() < 80);
        calm = 1;
      end
    end
    wait (requests.size() == 0 && !(in_valid && !in_stall) && !in_valid);
    wait (alu_expected.size() == 0);
    repeat (LATENCY + 4) @(posedge clk);
    $display("covered %0d results over all 16 opcodes, add seen %0d, div seen %0d",
             results_seen, ops_seen[OP_ADD], ops_seen[OP_DIV]);
    if (mismatches == 0 && table_errors == 0 && alu_expected.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/fxalu_pkg.sv
design/fxalu_mul.sv
design/fxalu_div.sv
design/fixed_point_q24_8_alu_top.sv
design/fxalu_check.sv
tb/sv/tb_top.sv
